@@ rtl/rtdnp_pkg.sv @@
`default_nettype none

package rtdnp_pkg;

    localparam int STORED_POINTS = 12;
    localparam int IDX_W = 4;
    localparam int V_W = 21;                // input voltage, uV
    localparam int VK_W = 31;               // voltage * 1000
    localparam int DEN_W = 38;              // gain_q16 * current_ua
    localparam int Q_W = 20;                // resistance, mohm
    localparam int CALR_W = 18;
    localparam int TEMP_W = 19;
    localparam int GAIN_W = 24;
    localparam int EXC_W = 14;
    localparam int DELTA_W = 8;

    localparam logic [Q_W-1:0] RES_MAX = '1;

    // delta = trunc(2*diff/25); |delta| saturates at 80 once |diff| >= 1013
    localparam logic [Q_W-1:0] DIFF_SAT = 20'd1013;
    localparam logic [DELTA_W-1:0] DELTA_LIMIT = 8'd80;
    localparam logic [10:0] RECIP_25 = 11'd1311;  // 2^15 / 25, rounded up
    localparam int RECIP_SH = 15;

    localparam logic [CALR_W-1:0] CAL_RES [STORED_POINTS] = '{
        18'd100000, 18'd107000, 18'd118000, 18'd124000, 18'd130000, 18'd137000,
        18'd80600, 18'd82500, 18'd113000, 18'd150000, 18'd115000, 18'd154000
    };

    localparam logic signed [TEMP_W-1:0] CAL_TEMP [STORED_POINTS] = '{
        19'sd0, 19'sd17000, 19'sd46000, 19'sd61000, 19'sd77000, 19'sd96000,
        -19'sd49000, -19'sd44000, 19'sd33000, 19'sd130000, 19'sd38000,
        19'sd141000
    };

    typedef struct packed {
        logic done;     // one-cycle pulse, quotient valid
        logic sat;      // quotient would exceed Q_W bits (or divisor zero)
    } t_div_stat;

endpackage

`default_nettype wire

@@ rtl/rtdnp_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// num = i_vk << 16; quotient limited to Q_W bits, overflow flagged.
module rtdnp_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [rtdnp_pkg::VK_W-1:0]  i_vk,
    input  wire logic [rtdnp_pkg::DEN_W-1:0] i_den,
    output logic [rtdnp_pkg::Q_W-1:0]        o_q,
    output rtdnp_pkg::t_div_stat             o_stat
);
    import rtdnp_pkg::*;

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [Q_W-1:0]   r_sh;     // low numerator bits in, quotient bits out
    logic [CNT_W-1:0] r_cnt;
    logic             r_sat;
    logic             r_done;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem0;

    // high part of the numerator: (vk << 16) >> Q_W
    assign rem0  = DEN_W'(i_vk[VK_W-1:Q_W-16]);
    assign trial = {r_rem, r_sh[Q_W-1]};
    assign diff  = trial - {1'b0, i_den};
    assign ge    = (trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem <= rem0;
                r_sh  <= {i_vk[Q_W-17:0], 16'd0};
                r_sat <= (rem0 >= i_den);
                r_cnt <= CNT_W'(Q_W);
            end else if (r_cnt != '0) begin
                r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_sh  <= {r_sh[Q_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_q         = r_sh;
    assign o_stat.done = r_done;
    assign o_stat.sat  = r_sat;

endmodule

`default_nettype wire

@@ rtl/rtd_nearest_point_temperature_core.sv @@
`default_nettype none

// Channel   | Valid    | Ready    | Payload
// ----------+----------+----------+-----------------------------------------
// request   | i_valid  | o_ready  | i_adc_voltage_uv
// result    | o_valid  | i_ready  | o_measured_resistance_mohm,
//           |          |          | o_calibrated_resistance_mohm,
//           |          |          | o_point_index, o_temperature_mdegc
// config    | APB      | pready=1 | paddr, pwdata, prdata
//
// One request at a time: an accepted request passes ST_MUL, ST_START, the
// 20-step restoring divider and the one-point-per-cycle table scan, then
// ST_DELTA and ST_DONE, where the result is registered before ST_IDLE again.
// Reset is synchronous, active low; clears control, loads register defaults.
// A result stalled by i_ready low does not block the next request; only the
// final write waits for it.
module rtd_nearest_point_temperature_core #(
    parameter int TABLE_POINTS = 12
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [rtdnp_pkg::V_W-1:0]          i_adc_voltage_uv,
    // result
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [rtdnp_pkg::Q_W-1:0]               o_measured_resistance_mohm,
    output logic [rtdnp_pkg::CALR_W-1:0]            o_calibrated_resistance_mohm,
    output logic [rtdnp_pkg::IDX_W-1:0]             o_point_index,
    output logic signed [rtdnp_pkg::TEMP_W-1:0]     o_temperature_mdegc,
    // configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [2:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import rtdnp_pkg::*;

    // points actually scanned, clamped to the stored table
    localparam int NSCAN = (TABLE_POINTS < 1) ? 1 :
                           (TABLE_POINTS > STORED_POINTS) ? STORED_POINTS : TABLE_POINTS;

    localparam logic REG_GAIN = 1'b0;
    localparam logic REG_EXC  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,     // products for numerator and divisor
        ST_START,   // kick the divider
        ST_DIV,     // wait for quotient
        ST_SCAN,    // one table point per cycle
        ST_DELTA,   // slope correction
        ST_DONE     // write output register
    } t_state;

    t_state r_state;

    // config registers
    logic [GAIN_W-1:0] r_gain;
    logic [EXC_W-1:0]  r_exc;

    // datapath
    logic [V_W-1:0]    r_v;
    logic [VK_W-1:0]   r_vk;
    logic [DEN_W-1:0]  r_den;
    logic [Q_W-1:0]    r_r;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_best;
    logic [Q_W-1:0]    r_best_d;
    logic signed [DELTA_W-1:0] r_delta;

    // output register
    logic                      r_o_valid;
    logic [Q_W-1:0]            r_o_res;
    logic [CALR_W-1:0]         r_o_cal;
    logic [IDX_W-1:0]          r_o_idx;
    logic signed [TEMP_W-1:0]  r_o_temp;

    logic [Q_W-1:0] div_q;
    t_div_stat      div_stat;

    logic           cfg_wr;

    logic [Q_W:0]   scan_diff;
    logic [Q_W-1:0] scan_d;
    logic           scan_take;

    logic [Q_W:0]   dl_diff;
    logic           dl_neg;
    logic [Q_W-1:0] dl_mag;
    logic [10:0]    dl_x;
    logic [21:0]    dl_prod;
    logic [DELTA_W-1:0] dl_m;

    logic signed [TEMP_W-1:0] temp_sum;

    // ---------------- divider ----------------
    rtdnp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_START),
        .i_vk    (r_vk),
        .i_den   (r_den),
        .o_q     (div_q),
        .o_stat  (div_stat)
    );

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            REG_GAIN: prdata = 32'(r_gain);
            REG_EXC:  prdata = 32'(r_exc);
            default:  prdata = '0;
        endcase
    end

    // ---------------- scan compare ----------------
    assign scan_diff = {1'b0, r_r} - (Q_W + 1)'(CAL_RES[r_idx]);
    assign scan_d    = scan_diff[Q_W] ? Q_W'(-scan_diff) : scan_diff[Q_W-1:0];
    // first point always taken; later ones only when strictly closer
    assign scan_take = (r_idx == '0) || (scan_d < r_best_d);

    // ---------------- slope correction ----------------
    // delta = trunc(2*diff/25), clamped to +-80
    assign dl_diff = {1'b0, r_r} - (Q_W + 1)'(CAL_RES[r_best]);
    assign dl_neg  = dl_diff[Q_W];
    assign dl_mag  = dl_neg ? Q_W'(-dl_diff) : dl_diff[Q_W-1:0];
    assign dl_x    = {dl_mag[9:0], 1'b0};
    assign dl_prod = dl_x * RECIP_25;
    assign dl_m    = (dl_mag >= DIFF_SAT) ? DELTA_LIMIT : DELTA_W'(dl_prod >> RECIP_SH);

    assign temp_sum = CAL_TEMP[r_best] + TEMP_W'(r_delta);

    // ---------------- control and registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_gain    <= GAIN_W'(522650);
            r_exc     <= EXC_W'(1006);
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_GAIN: r_gain <= pwdata[GAIN_W-1:0];
                    REG_EXC:  r_exc  <= pwdata[EXC_W-1:0];
                    default:  ;
                endcase
            end

            // in ST_DONE the output write below decides the flag
            if (r_o_valid && i_ready && (r_state != ST_DONE)) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_v     <= i_adc_voltage_uv;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_vk    <= VK_W'(r_v * 10'd1000);
                    r_den   <= DEN_W'(r_gain * r_exc);
                    r_state <= ST_START;
                end
                ST_START: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        r_r     <= div_stat.sat ? RES_MAX : div_q;
                        r_idx   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (scan_take) begin
                        r_best   <= r_idx;
                        r_best_d <= scan_d;
                    end
                    if (r_idx == IDX_W'(NSCAN - 1)) begin
                        r_state <= ST_DELTA;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_DELTA: begin
                    r_delta <= dl_neg ? -$signed(dl_m) : $signed(dl_m);
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    // wait until the output register is free
                    if (!r_o_valid || i_ready) begin
                        r_o_valid <= 1'b1;
                        r_o_res   <= r_r;
                        r_o_cal   <= CAL_RES[r_best];
                        r_o_idx   <= r_best;
                        r_o_temp  <= temp_sum;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_ready                      = (r_state == ST_IDLE);
    assign o_valid                      = r_o_valid;
    assign o_measured_resistance_mohm   = r_o_res;
    assign o_calibrated_resistance_mohm = r_o_cal;
    assign o_point_index                = r_o_idx;
    assign o_temperature_mdegc          = r_o_temp;

endmodule

`default_nettype wire

@@ bench/rtd_reading_checker.sv @@
module rtd_reading_checker #(
    parameter int TABLE_POINTS = 12,
    parameter logic [2:0] GAIN_ADDR = 3'd0,
    parameter logic [2:0] EXC_ADDR = 3'd4
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire logic                               o_ready,
    input  wire logic [rtdnp_pkg::V_W-1:0]          i_adc_voltage_uv,
    input  wire logic                               o_valid,
    input  wire logic                               i_ready,
    input  wire logic [rtdnp_pkg::Q_W-1:0]          o_measured_resistance_mohm,
    input  wire logic [rtdnp_pkg::CALR_W-1:0]       o_calibrated_resistance_mohm,
    input  wire logic [rtdnp_pkg::IDX_W-1:0]        o_point_index,
    input  wire logic signed [rtdnp_pkg::TEMP_W-1:0] o_temperature_mdegc,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [2:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    input  wire logic                               pready,
    output int                                      o_fail_count,
    output int                                      o_pending_count
);

    localparam int STORE_SIZE = 12;
    localparam int SCAN_POINTS = (TABLE_POINTS < 1) ? 1 :
                                 (TABLE_POINTS > STORE_SIZE) ? STORE_SIZE : TABLE_POINTS;
    localparam longint unsigned RES_LIMIT = 1048575;
    localparam longint DELTA_CLAMP = 80;
    localparam logic [23:0] GAIN_DEFAULT = 24'd522650;
    localparam logic [13:0] CURRENT_DEFAULT = 14'd1006;

    // board calibration points, unsorted
    localparam longint POINT_MOHM [STORE_SIZE] = '{
        100000, 107000, 118000, 124000, 130000, 137000,
        80600, 82500, 113000, 150000, 115000, 154000
    };
    localparam longint POINT_MDEGC [STORE_SIZE] = '{
        0, 17000, 46000, 61000, 77000, 96000,
        -49000, -44000, 33000, 130000, 38000, 141000
    };

    typedef struct packed {
        logic [rtdnp_pkg::Q_W-1:0]           measured_mohm;
        logic [rtdnp_pkg::CALR_W-1:0]        point_mohm;
        logic [rtdnp_pkg::IDX_W-1:0]         point_index;
        logic signed [rtdnp_pkg::TEMP_W-1:0] temp_mdegc;
    } t_reading;

    logic [23:0] gain_q16;
    logic [13:0] current_ua;
    t_reading    expected_readings [$];
    int          mismatches = 0;

    function automatic t_reading convert_voltage(input logic [rtdnp_pkg::V_W-1:0] uv);
        t_reading        rd;
        longint unsigned den;
        longint unsigned num;
        longint unsigned mohm;
        longint          gap;
        longint          best_gap;
        longint          delta;
        int              best;
        den = longint'(gain_q16) * longint'(current_ua);
        num = longint'(uv) * 64'd1000 * 64'd65536;
        if (den == 0) begin
            mohm = RES_LIMIT;
        end else begin
            mohm = num / den;
            if (mohm > RES_LIMIT) mohm = RES_LIMIT;
        end
        // first point wins a tie: a later one must be strictly closer
        best = 0;
        best_gap = longint'(mohm) - POINT_MOHM[0];
        if (best_gap < 0) best_gap = -best_gap;
        for (int k = 1; k < SCAN_POINTS; k++) begin
            gap = longint'(mohm) - POINT_MOHM[k];
            if (gap < 0) gap = -gap;
            if (gap < best_gap) begin
                best = k;
                best_gap = gap;
            end
        end
        delta = ((longint'(mohm) - POINT_MOHM[best]) * 2) / 25;
        if (delta > DELTA_CLAMP) delta = DELTA_CLAMP;
        else if (delta < -DELTA_CLAMP) delta = -DELTA_CLAMP;
        rd.measured_mohm = mohm[rtdnp_pkg::Q_W-1:0];
        rd.point_mohm = POINT_MOHM[best][rtdnp_pkg::CALR_W-1:0];
        rd.point_index = best[rtdnp_pkg::IDX_W-1:0];
        rd.temp_mdegc = 19'(POINT_MDEGC[best] + delta);
        return rd;
    endfunction

    task automatic report_field(input string what, input logic signed [63:0] want,
                                input logic signed [63:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        if (!i_rst_n) begin
            gain_q16 = GAIN_DEFAULT;
            current_ua = CURRENT_DEFAULT;
            expected_readings.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == GAIN_ADDR) gain_q16 = pwdata[23:0];
                else if (paddr == EXC_ADDR) current_ua = pwdata[13:0];
            end
            if (i_valid && o_ready)
                expected_readings.push_back(convert_voltage(i_adc_voltage_uv));
            if (o_valid && i_ready) begin
                got = '{o_measured_resistance_mohm, o_calibrated_resistance_mohm,
                        o_point_index, o_temperature_mdegc};
                if (expected_readings.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no request outstanding, expected none, actual %0d",
                             $time, got.measured_mohm);
                end else begin
                    want = expected_readings.pop_front();
                    if (got.measured_mohm !== want.measured_mohm)
                        report_field("measured resistance", want.measured_mohm,
                                     got.measured_mohm);
                    if (got.point_mohm !== want.point_mohm)
                        report_field("point resistance", want.point_mohm, got.point_mohm);
                    if (got.point_index !== want.point_index)
                        report_field("point index", want.point_index, got.point_index);
                    if (got.temp_mdegc !== want.temp_mdegc)
                        report_field("temperature", want.temp_mdegc, got.temp_mdegc);
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending_count <= expected_readings.size();
    end

endmodule

@@ bench/rtd_nearest_point_temperature_core_tb.sv @@
// Stimulus and verdict for the RTD nearest-point core. Checking lives in
// rtd_reading_checker, which watches the same wires.
module rtd_nearest_point_temperature_core_tb;

    localparam int TABLE_POINTS = 12;
    // register map: gain at index 0, excitation current at index 1, 4 bytes apart
    localparam logic [2:0] GAIN_ADDR = 3'd0;
    localparam logic [2:0] EXC_ADDR = 3'd4;

    // The receiver can stall a long run at 85% idle, yet quiet stretches
    // of this length only happen if the core hangs.
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 80;

    localparam logic [23:0] GAIN_DEFAULT = 24'd522650;
    localparam logic [13:0] CURRENT_DEFAULT = 14'd1006;
    localparam longint unsigned UNITY_SCALE = 64'd65536000;   // 1000 * 2^16
    localparam longint unsigned UV_TOP = 64'd2097151;

    localparam int DEFAULT_ITEMS = 150;
    localparam int RANDOM_SETTINGS = 6;
    localparam int RANDOM_SETTING_ITEMS = 100;

    // Fixed register settings. The first (gain 1.0, 1000 uA) makes the
    // resistance equal the voltage, so the directed items hit exact values.
    localparam int FIXED_SETTINGS = 9;
    localparam logic [23:0] SET_GAIN [FIXED_SETTINGS] = '{
        24'd65536, 24'd1, 24'd16777215, 24'd16777215, 24'd1,
        24'd0, 24'd522650, 24'd0, 24'd522650
    };
    localparam logic [13:0] SET_CURRENT [FIXED_SETTINGS] = '{
        14'd1000, 14'd1, 14'd10000, 14'd1, 14'd10000,
        14'd1006, 14'd0, 14'd0, 14'd1006
    };
    localparam int SET_ITEMS [FIXED_SETTINGS] = '{200, 60, 60, 60, 60, 40, 40, 20, 120};

    // Directed voltages under unity scaling (voltage == resistance):
    // field extremes and saturation edge, exact points incl. the extreme
    // ones, equidistant ties (lower index must win), and the correction
    // around its rounding and clamp edges.
    localparam int DIRECTED_COUNT = 21;
    localparam logic [20:0] DIRECTED_UV [DIRECTED_COUNT] = '{
        21'd0, 21'd2097151, 21'd2048000, 21'd1048575, 21'd1048576,
        21'd80600, 21'd154000, 21'd100000,
        21'd103500, 21'd81550, 21'd114000, 21'd152000, 21'd116500,
        21'd101012, 21'd101013, 21'd98987, 21'd79600, 21'd155000,
        21'd100012, 21'd99987, 21'd100013
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [20:0] i_adc_voltage_uv = '0;
    logic        i_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;

    wire logic                                o_ready;
    wire logic                                o_valid;
    wire logic [rtdnp_pkg::Q_W-1:0]           o_measured_resistance_mohm;
    wire logic [rtdnp_pkg::CALR_W-1:0]        o_calibrated_resistance_mohm;
    wire logic [rtdnp_pkg::IDX_W-1:0]         o_point_index;
    wire logic signed [rtdnp_pkg::TEMP_W-1:0] o_temperature_mdegc;
    wire logic [31:0]                         prdata;
    wire logic                                pready;

    int fail_count;
    int pending_count;

    // idle rates in percent, switched by progress through the run
    int sender_idle_pct = 7;
    int receiver_idle_pct = 85;
    int requests_sent = 0;
    int planned_requests = 0;

    // what was last written, used only to aim voltages at the table
    logic [23:0] aim_gain = GAIN_DEFAULT;
    logic [13:0] aim_current = CURRENT_DEFAULT;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rtd_nearest_point_temperature_core #(
        .TABLE_POINTS(TABLE_POINTS)
    ) dut (
        .i_clk                        (i_clk),
        .i_rst_n                      (i_rst_n),
        .i_valid                      (i_valid),
        .o_ready                      (o_ready),
        .i_adc_voltage_uv             (i_adc_voltage_uv),
        .o_valid                      (o_valid),
        .i_ready                      (i_ready),
        .o_measured_resistance_mohm   (o_measured_resistance_mohm),
        .o_calibrated_resistance_mohm (o_calibrated_resistance_mohm),
        .o_point_index                (o_point_index),
        .o_temperature_mdegc          (o_temperature_mdegc),
        .psel                         (psel),
        .penable                      (penable),
        .pwrite                       (pwrite),
        .paddr                        (paddr),
        .pwdata                       (pwdata),
        .prdata                       (prdata),
        .pready                       (pready)
    );

    rtd_reading_checker #(
        .TABLE_POINTS(TABLE_POINTS),
        .GAIN_ADDR   (GAIN_ADDR),
        .EXC_ADDR    (EXC_ADDR)
    ) reading_check (
        .i_clk                        (i_clk),
        .i_rst_n                      (i_rst_n),
        .i_valid                      (i_valid),
        .o_ready                      (o_ready),
        .i_adc_voltage_uv             (i_adc_voltage_uv),
        .o_valid                      (o_valid),
        .i_ready                      (i_ready),
        .o_measured_resistance_mohm   (o_measured_resistance_mohm),
        .o_calibrated_resistance_mohm (o_calibrated_resistance_mohm),
        .o_point_index                (o_point_index),
        .o_temperature_mdegc          (o_temperature_mdegc),
        .psel                         (psel),
        .penable                      (penable),
        .pwrite                       (pwrite),
        .paddr                        (paddr),
        .pwdata                       (pwdata),
        .pready                       (pready),
        .o_fail_count                 (fail_count),
        .o_pending_count              (pending_count)
    );

    // Result side backpressure: a fresh coin every cycle.
    always @(posedge i_clk) i_ready <= ($urandom_range(99) >= receiver_idle_pct);

    // APB write: setup cycle, access cycle, then an idle phase with psel low so the
    // next transfer never re-drives psel in the same time step.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Registers change only with the core idle: drop valid, let the
    // checker's outstanding count catch up, then wait until it reaches zero.
    // Upper pwdata bits are junk on purpose; the registers keep their width.
    task automatic apply_setting(input logic [23:0] gain, input logic [13:0] current_ua);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        write_register(GAIN_ADDR, {8'($urandom), gain});
        write_register(EXC_ADDR, {18'($urandom), current_ua});
        aim_gain = gain;
        aim_current = current_ua;
    endtask

    // One request. Valid stays up across back-to-back requests and is dropped
    // when the sender decides to idle (and by apply_setting and the final drain).
    task automatic send_voltage(input logic [20:0] uv);
        // idle schedule: sender light / receiver heavy, then swapped, then none
        if (requests_sent < planned_requests / 3) begin
            sender_idle_pct = 7;
            receiver_idle_pct = 85;
        end else if (requests_sent < (2 * planned_requests) / 3) begin
            sender_idle_pct = 85;
            receiver_idle_pct = 7;
        end else begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
        end
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_adc_voltage_uv <= uv;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        requests_sent++;
    endtask

    // Mostly voltages that land near the calibration points under the
    // current gain and current; the rest spans the whole 21-bit field.
    function automatic logic [20:0] pick_voltage();
        longint unsigned scale;
        longint unsigned target;
        int              choice;
        scale = longint'(aim_gain) * longint'(aim_current);
        choice = $urandom_range(99);
        if (choice < 15)
            return 21'($urandom_range(2097151));
        if (choice < 20) begin
            case ($urandom_range(2))
                0: return '0;
                1: return '1;
                default: return 21'd2048000;
            endcase
        end
        if (choice < 60)
            target = longint'(rtdnp_pkg::CAL_RES[$urandom_range(rtdnp_pkg::STORED_POINTS - 1)])
                     - 1500 + $urandom_range(3000);
        else
            target = $urandom_range(157000, 78000);
        // invert the conversion; the +0/+1 jitter covers both sides of rounding
        target = target * scale / UNITY_SCALE + $urandom_range(1);
        return (target > UV_TOP) ? '1 : 21'(target);
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) send_voltage(pick_voltage());
    endtask

    // Watchdog: ends the run with an error if nothing moves on the request, result or register side.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[rtd_nearest_point_temperature_core] ERROR");
        $finish;
    end

    initial begin
        planned_requests = DEFAULT_ITEMS + DIRECTED_COUNT
                         + RANDOM_SETTINGS * RANDOM_SETTING_ITEMS;
        for (int s = 0; s < FIXED_SETTINGS; s++) planned_requests += SET_ITEMS[s];

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults untouched first: proves the register reset values
        send_random(DEFAULT_ITEMS);

        for (int s = 0; s < FIXED_SETTINGS; s++) begin
            apply_setting(SET_GAIN[s], SET_CURRENT[s]);
            if (s == 0)
                for (int d = 0; d < DIRECTED_COUNT; d++) send_voltage(DIRECTED_UV[d]);
            send_random(SET_ITEMS[s]);
        end

        // plausible front-end settings around the nominal gain and current
        for (int s = 0; s < RANDOM_SETTINGS; s++) begin
            apply_setting(24'($urandom_range(800000, 300000)),
                          14'($urandom_range(2000, 500)));
            send_random(RANDOM_SETTING_ITEMS);
        end

        // drain: every request answered, then a quiet tail for strays
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("[rtd_nearest_point_temperature_core] OK");
        else
            $display("[rtd_nearest_point_temperature_core] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rtdnp_pkg.sv
rtl/rtdnp_div.sv
rtl/rtd_nearest_point_temperature_core.sv
bench/rtd_reading_checker.sv
bench/rtd_nearest_point_temperature_core_tb.sv
